// ----- design/reno_congestion_window_core_macros.svh -----
// ----------------------------------------------------------------------------
// reno congestion window core: assertion macros
// shared assertion forms, clocked on clk and disabled during arst_n
// ----------------------------------------------------------------------------
`ifndef RENO_CONGESTION_WINDOW_CORE_MACROS_SVH
`define RENO_CONGESTION_WINDOW_CORE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define RCW_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define RCW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/rcw_pkg.sv -----
// ----------------------------------------------------------------------------
// rcw_pkg
// types and constants shared by the congestion window core and its divider
// ----------------------------------------------------------------------------
package rcw_pkg;

	localparam int unsigned WIN_W     = 32;
	localparam int unsigned MSS_W     = 16;
	localparam int unsigned LIMIT_W   = 4;
	localparam int unsigned PKT_W     = 10;
	localparam int unsigned KIND_W    = 2;
	localparam int unsigned MODE_W    = 2;
	localparam int unsigned IDX_W     = 3;
	localparam int unsigned STEP_W    = 5;
	localparam int unsigned S_DATA_W  = 16;
	localparam int unsigned M_DATA_W  = 80;
	localparam int unsigned M_USED_W  = 2 * WIN_W + MODE_W + 1 + PKT_W;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_SEGMENT_SIZE  = 3'd0;
	localparam logic [IDX_W-1:0] REG_INIT_THRESH   = 3'd1;
	localparam logic [IDX_W-1:0] REG_TIMEOUT_FLOOR = 3'd2;
	localparam logic [IDX_W-1:0] REG_DUP_ACK_LIMIT = 3'd3;
	localparam logic [IDX_W-1:0] REG_RESEND_CAP    = 3'd4;

	// reset values of the configuration registers
	localparam logic [MSS_W-1:0]   RST_SEGMENT_SIZE  = 16'd1000;
	localparam logic [WIN_W-1:0]   RST_INIT_THRESH   = 32'd4096000;
	localparam logic [WIN_W-1:0]   RST_TIMEOUT_FLOOR = 32'd4096000;
	localparam logic [LIMIT_W-1:0] RST_DUP_ACK_LIMIT = 4'd3;
	localparam logic [PKT_W-1:0]   RST_RESEND_CAP    = 10'd128;

	typedef enum logic [KIND_W-1:0] {
		EV_NEW_ACK = 2'd0,
		EV_DUP_ACK = 2'd1,
		EV_TIMEOUT = 2'd2
	} kind_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_SLOW  = 2'd0,
		MODE_AVOID = 2'd1,
		MODE_RECOV = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_WAIT,
		ST_COMMIT
	} st_t;

	// divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ----- design/reno_congestion_window_core.sv -----
// ----------------------------------------------------------------------------
// reno_congestion_window_core
// tcp reno congestion window, threshold and mode tracker, one result per event
// ----------------------------------------------------------------------------
// Each input transaction is one sender event (new ack, duplicate ack or
// retransmit timeout) and produces exactly one output transaction carrying the
// window, threshold and mode after the event, the fast retransmit flag and the
// bulk resend count. Events are handled one at a time and s_axis_tready is low
// while an event is in work. A new ack in congestion avoidance with a nonzero
// window goes from accept to result through these steps: form mss*mss in the
// multiplier, launch the serial divider, run the divider steps (one quotient
// bit each), let the divider flag done, and commit. The next event is taken
// in the same cycle in which that result shows. Every other event goes from
// accept straight to the commit step and is likewise followed by the next
// event as its result shows. The result sits in an output register, so the
// next event is taken while the previous result still waits on
// m_axis_tready; a commit waits only if that register is still full.
// Window and threshold saturate at 2^32-1. Configuration writes through
// cfg_we / cfg_index / cfg_wdata are meant for idle periods; indexes past the
// register list are ignored. The initial threshold only matters at reset, where
// the threshold loads its reset value, so a write to that index has no effect.
// No clearing pass after reset.
// ----------------------------------------------------------------------------
`include "reno_congestion_window_core_macros.svh"

module reno_congestion_window_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write port
	input  logic                            cfg_we,
	input  logic [rcw_pkg::IDX_W-1:0]       cfg_index,
	input  logic [rcw_pkg::WIN_W-1:0]       cfg_wdata,
	// event stream
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [rcw_pkg::S_DATA_W-1:0]    s_axis_tdata,   // [9:0] outstanding, rest zero
	input  logic [rcw_pkg::KIND_W-1:0]      s_axis_tuser,   // [1:0] req_type
	// result stream
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [31:0] window_now, [63:32] threshold_now, [65:64] mode_now,
	// [66] retransmit_front, [76:67] bulk_resend_count, rest zero
	output logic [rcw_pkg::M_DATA_W-1:0]    m_axis_tdata
);

	// configuration registers
	logic [rcw_pkg::MSS_W-1:0]    mss_q;
	logic [rcw_pkg::WIN_W-1:0]    floor_q;
	logic [rcw_pkg::LIMIT_W-1:0]  limit_q;
	logic [rcw_pkg::PKT_W-1:0]    cap_q;

	// congestion state
	logic [rcw_pkg::WIN_W-1:0]    win_q;
	logic [rcw_pkg::WIN_W-1:0]    thr_q;
	rcw_pkg::mode_t               mode_q;
	logic [rcw_pkg::LIMIT_W-1:0]  cnt_q;

	// latched event
	rcw_pkg::kind_t               kind_q;
	logic [rcw_pkg::PKT_W-1:0]    outst_q;

	// sequencer and divider
	rcw_pkg::st_t                 state_q, state_d;
	logic [rcw_pkg::WIN_W-1:0]    sq_q;
	logic [rcw_pkg::WIN_W-1:0]    quotient;
	rcw_pkg::div_stat_t           div_stat;
	logic                         div_start;
	logic                         commit;
	logic                         in_accept;
	logic                         needs_div;

	// output register
	logic                         out_valid_q;
	logic [rcw_pkg::WIN_W-1:0]    out_win_q;
	logic [rcw_pkg::WIN_W-1:0]    out_thr_q;
	rcw_pkg::mode_t               out_mode_q;
	logic                         out_retx_q;
	logic [rcw_pkg::PKT_W-1:0]    out_bulk_q;
	logic                         out_free;

	// next-state values of the commit step
	logic [rcw_pkg::WIN_W-1:0]    half;
	logic [rcw_pkg::WIN_W-1:0]    fr_thresh;
	logic [rcw_pkg::LIMIT_W-1:0]  cnt_inc;
	logic                         fast_retx;
	logic [rcw_pkg::WIN_W-1:0]    add_a;
	logic [rcw_pkg::WIN_W:0]      add_b;
	logic [rcw_pkg::WIN_W+1:0]    add_sum;
	logic [rcw_pkg::WIN_W-1:0]    sum_sat;
	logic [rcw_pkg::WIN_W-1:0]    win_n;
	logic [rcw_pkg::WIN_W-1:0]    thr_n;
	rcw_pkg::mode_t               mode_n;
	logic [rcw_pkg::LIMIT_W-1:0]  cnt_n;
	logic                         retx_n;
	logic [rcw_pkg::PKT_W-1:0]    bulk_n;

	assign in_accept = s_axis_tvalid && s_axis_tready;
	assign out_free  = !out_valid_q || m_axis_tready;

	// the divide is only needed for a new ack in avoidance with a nonzero window
	assign needs_div = (rcw_pkg::kind_t'(s_axis_tuser) == rcw_pkg::EV_NEW_ACK)
		&& (mode_q == rcw_pkg::MODE_AVOID) && (win_q != '0);

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mss_q         <= rcw_pkg::RST_SEGMENT_SIZE;
			floor_q       <= rcw_pkg::RST_TIMEOUT_FLOOR;
			limit_q       <= rcw_pkg::RST_DUP_ACK_LIMIT;
			cap_q         <= rcw_pkg::RST_RESEND_CAP;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rcw_pkg::REG_SEGMENT_SIZE:  mss_q         <= cfg_wdata[rcw_pkg::MSS_W-1:0];
				// only read at reset, which loads the constant
				rcw_pkg::REG_INIT_THRESH:   ;
				rcw_pkg::REG_TIMEOUT_FLOOR: floor_q       <= cfg_wdata;
				rcw_pkg::REG_DUP_ACK_LIMIT: limit_q       <= cfg_wdata[rcw_pkg::LIMIT_W-1:0];
				rcw_pkg::REG_RESEND_CAP:    cap_q         <= cfg_wdata[rcw_pkg::PKT_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rcw_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rcw_pkg::ST_IDLE: begin
				if (in_accept) begin
					state_d = needs_div ? rcw_pkg::ST_MUL : rcw_pkg::ST_COMMIT;
				end
			end
			rcw_pkg::ST_MUL:    state_d = rcw_pkg::ST_DIV;
			rcw_pkg::ST_DIV:    state_d = rcw_pkg::ST_WAIT;
			rcw_pkg::ST_WAIT: begin
				if (div_stat.done) begin
					state_d = rcw_pkg::ST_COMMIT;
				end
			end
			rcw_pkg::ST_COMMIT: begin
				if (out_free) begin
					state_d = rcw_pkg::ST_IDLE;
				end
			end
			default: state_d = rcw_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = (state_q == rcw_pkg::ST_IDLE);
		div_start     = (state_q == rcw_pkg::ST_DIV);
		commit        = (state_q == rcw_pkg::ST_COMMIT) && out_free;
	end

	// latch the event on accept
	always_ff @(posedge clk) begin
		if (in_accept) begin
			kind_q  <= rcw_pkg::kind_t'(s_axis_tuser);
			outst_q <= s_axis_tdata[rcw_pkg::PKT_W-1:0];
		end
	end

	// mss squared, registered before it feeds the divider
	always_ff @(posedge clk) begin
		if (state_q == rcw_pkg::ST_MUL) begin
			sq_q <= {16'd0, mss_q} * {16'd0, mss_q};
		end
	end

	// serial divider for the avoidance increment mss*mss/window
	rcw_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sq_q),
		.divisor  (win_q),
		.quotient (quotient),
		.stat     (div_stat)
	);

	// ---------------- commit step ----------------
	assign half      = win_q >> 1;
	assign fr_thresh = (half < {16'd0, mss_q}) ? {16'd0, mss_q} : half;
	assign cnt_inc   = cnt_q + 1'b1;
	// duplicate ack outside fast recovery hitting the limit
	assign fast_retx = (kind_q == rcw_pkg::EV_DUP_ACK)
		&& ((mode_q == rcw_pkg::MODE_SLOW) || (mode_q == rcw_pkg::MODE_AVOID))
		&& (cnt_inc == limit_q);

	// one saturating adder, operands picked by event
	always_comb begin
		if (fast_retx) begin
			add_a = fr_thresh;
			add_b = {15'd0, mss_q, 1'b0} + {17'd0, mss_q};
		end else if ((kind_q == rcw_pkg::EV_NEW_ACK) && (mode_q == rcw_pkg::MODE_AVOID)
				&& (win_q != '0)) begin
			add_a = win_q;
			add_b = {1'b0, quotient};
		end else begin
			add_a = win_q;
			add_b = {17'd0, mss_q};
		end
	end

	assign add_sum = {2'b00, add_a} + {1'b0, add_b};
	assign sum_sat = (add_sum[rcw_pkg::WIN_W+1:rcw_pkg::WIN_W] != 2'b00)
		? '1 : add_sum[rcw_pkg::WIN_W-1:0];

	always_comb begin
		win_n  = win_q;
		thr_n  = thr_q;
		mode_n = mode_q;
		cnt_n  = cnt_q;
		retx_n = 1'b0;
		bulk_n = '0;
		// an unused mode code leaves everything as it is
		if ((mode_q == rcw_pkg::MODE_SLOW) || (mode_q == rcw_pkg::MODE_AVOID)
				|| (mode_q == rcw_pkg::MODE_RECOV)) begin
			case (kind_q)
				rcw_pkg::EV_TIMEOUT: begin
					thr_n  = (half >= floor_q) ? half : floor_q;
					win_n  = {16'd0, mss_q};
					cnt_n  = '0;
					mode_n = rcw_pkg::MODE_SLOW;
					bulk_n = (outst_q < cap_q) ? (outst_q >> 1) : cap_q;
				end
				rcw_pkg::EV_NEW_ACK: begin
					cnt_n = '0;
					unique case (mode_q)
						rcw_pkg::MODE_SLOW: begin
							win_n  = sum_sat;
							mode_n = (sum_sat >= thr_q) ? rcw_pkg::MODE_AVOID
								: rcw_pkg::MODE_SLOW;
						end
						rcw_pkg::MODE_AVOID: win_n = sum_sat;
						rcw_pkg::MODE_RECOV: begin
							win_n  = thr_q;
							mode_n = rcw_pkg::MODE_AVOID;
						end
						default: ;
					endcase
				end
				rcw_pkg::EV_DUP_ACK: begin
					if (mode_q == rcw_pkg::MODE_RECOV) begin
						win_n = sum_sat;
					end else if (fast_retx) begin
						thr_n  = fr_thresh;
						win_n  = sum_sat;
						cnt_n  = '0;
						mode_n = rcw_pkg::MODE_RECOV;
						retx_n = 1'b1;
					end else begin
						cnt_n = cnt_inc;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q  <= {16'd0, rcw_pkg::RST_SEGMENT_SIZE};
			thr_q  <= rcw_pkg::RST_INIT_THRESH;
			mode_q <= rcw_pkg::MODE_SLOW;
			cnt_q  <= '0;
		end else if (commit) begin
			win_q  <= win_n;
			thr_q  <= thr_n;
			mode_q <= mode_n;
			cnt_q  <= cnt_n;
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_win_q  <= win_n;
			out_thr_q  <= thr_n;
			out_mode_q <= mode_n;
			out_retx_q <= retx_n;
			out_bulk_q <= bulk_n;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(rcw_pkg::M_DATA_W - rcw_pkg::M_USED_W){1'b0}},
		out_bulk_q, out_retx_q, out_mode_q, out_thr_q, out_win_q};

	// ---------------- assertions ----------------
	`RCW_ASSERT_NEXT(a_busy_after_accept, in_accept, !s_axis_tready,
		"ready high after accept")
	`RCW_ASSERT_SAME(a_div_done_in_wait, div_stat.done, state_q == rcw_pkg::ST_WAIT,
		"stray divider done")
	`RCW_ASSERT_SAME(a_div_busy_in_wait, div_stat.busy, state_q == rcw_pkg::ST_WAIT,
		"divider busy outside wait")
	`RCW_ASSERT_SAME(a_retx_means_recovery, m_axis_tvalid && out_retx_q,
		out_mode_q == rcw_pkg::MODE_RECOV, "retransmit outside recovery")
	`RCW_ASSERT_SAME(a_bulk_means_timeout, m_axis_tvalid && (out_bulk_q != '0),
		(out_mode_q == rcw_pkg::MODE_SLOW) && !out_retx_q, "bulk resend outside timeout")

endmodule

// ----- design/rcw_div.sv -----
// ----------------------------------------------------------------------------
// rcw_div
// restoring radix-2 divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rcw_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rcw_pkg::WIN_W-1:0]     dividend,
	input  logic [rcw_pkg::WIN_W-1:0]     divisor,
	output logic [rcw_pkg::WIN_W-1:0]     quotient,
	output rcw_pkg::div_stat_t            stat
);

	logic                              busy_q;
	logic                              done_q;
	logic [rcw_pkg::STEP_W-1:0]        step_q;
	logic [rcw_pkg::WIN_W-1:0]         rem_q;
	logic [rcw_pkg::WIN_W-1:0]         quo_q;
	logic [rcw_pkg::WIN_W-1:0]         dsr_q;

	logic [rcw_pkg::WIN_W:0]           shifted;
	logic [rcw_pkg::WIN_W:0]           diff;
	logic                              fits;

	assign shifted = {rem_q, quo_q[rcw_pkg::WIN_W-1]};
	assign fits    = shifted >= {1'b0, dsr_q};
	assign diff    = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (&step_q) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[rcw_pkg::WIN_W-1:0] : shifted[rcw_pkg::WIN_W-1:0];
			quo_q <= {quo_q[rcw_pkg::WIN_W-2:0], fits};
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule
